// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the bicycle step block.
// Clocked on clk, disabled while arst_n is low; empty in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KBS_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define KBS_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define KBS_ASSERT_NXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define KBS_ASSERT(lbl, cond)
`define KBS_ASSERT_IMP(lbl, pre, post)
`define KBS_ASSERT_NXT(lbl, pre, post)
`endif
`endif

// ----- hw/rtl/kbs_pkg.sv -----
// Package for the kinematic bicycle step block: widths, constants, CORDIC table,
// saturation helper. No dependencies.
`default_nettype none
package kbs_pkg;
	localparam int FRAC_BITS    = 16;
	localparam int CORDIC_ITERS = 16;
	localparam int CF           = 30;
	localparam int CNT_W        = $clog2(CORDIC_ITERS + 1);

	localparam int VEL_W   = 24;
	localparam int SR_W    = 21;
	localparam int POS_W   = 32;
	localparam int YAW_W   = 19;
	localparam int STEER_W = 17;
	localparam int LW_W    = 24;
	localparam int DT_W    = 16;
	localparam int TRIG_W  = 18;
	localparam int CX_W    = 33;
	localparam int CZ_W    = 34;
	localparam int MOP_W   = 25;
	localparam int PROD_W  = 2 * MOP_W;
	localparam int DN_W    = 44;
	localparam int DD_W    = 26;
	localparam int T_W     = 46;
	localparam int FOLD_K  = 19;

	localparam logic [0:0] REG_WHEELBASE = 1'b0;
	localparam logic [0:0] REG_TIME_STEP = 1'b1;

	localparam longint PI_Q30      = 64'd3373259426;
	localparam longint HALF_PI_Q30 = 64'd1686629713;
	localparam longint CORDIC_K    = 64'd652032874;
	localparam longint RND         = 64'd1 << (CF - FRAC_BITS - 1);
	localparam longint PI_FRAC     = (PI_Q30 + RND) >> (CF - FRAC_BITS);
	localparam longint PI4_FRAC    = ((PI_Q30 / 4) + 1 + RND) >> (CF - FRAC_BITS);

	localparam logic signed [T_W-1:0] PI_T     = T_W'(PI_FRAC);
	localparam logic signed [T_W-1:0] PI4_T    = T_W'(PI4_FRAC);
	localparam logic [FOLD_K-1:0]     TWO_PI_R = FOLD_K'(2 * PI_FRAC);
	// 2^FOLD_K mod 2*pi, used to fold the high bits back into the low ones
	localparam logic signed [MOP_W-1:0] FOLD_C = MOP_W'((64'd1 << FOLD_K) - 2 * PI_FRAC);
	localparam logic signed [CZ_W-1:0] PI_Z    = CZ_W'(PI_Q30);
	localparam logic signed [CZ_W-1:0] HALF_Z  = CZ_W'(HALF_PI_Q30);
	localparam logic signed [CX_W-1:0] K_X     = CX_W'(CORDIC_K);

	localparam logic signed [POS_W+1:0] SAT_MAX = (POS_W+2)'(64'h7FFF_FFFF);
	localparam logic signed [POS_W+1:0] SAT_MIN = -SAT_MAX - 1;

	function automatic logic signed [CZ_W-1:0] atan_lut(input logic [4:0] idx);
		logic signed [CZ_W-1:0] v;
		case (idx)
			5'd0:  v = CZ_W'(64'd843314857);
			5'd1:  v = CZ_W'(64'd497837829);
			5'd2:  v = CZ_W'(64'd263043837);
			5'd3:  v = CZ_W'(64'd133525159);
			5'd4:  v = CZ_W'(64'd67021687);
			5'd5:  v = CZ_W'(64'd33543516);
			5'd6:  v = CZ_W'(64'd16775851);
			5'd7:  v = CZ_W'(64'd8388437);
			5'd8:  v = CZ_W'(64'd4194283);
			5'd9:  v = CZ_W'(64'd2097149);
			5'd10: v = CZ_W'(64'd1048576);
			5'd11: v = CZ_W'(64'd524288);
			5'd12: v = CZ_W'(64'd262144);
			5'd13: v = CZ_W'(64'd131072);
			5'd14: v = CZ_W'(64'd65536);
			5'd15: v = CZ_W'(64'd32768);
			5'd16: v = CZ_W'(64'd16384);
			5'd17: v = CZ_W'(64'd8192);
			5'd18: v = CZ_W'(64'd4096);
			5'd19: v = CZ_W'(64'd2048);
			5'd20: v = CZ_W'(64'd1024);
			5'd21: v = CZ_W'(64'd512);
			5'd22: v = CZ_W'(64'd256);
			5'd23: v = CZ_W'(64'd128);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[POS_W-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/kbs_if.sv -----
// Request and result channel interfaces of the bicycle step block.
// Depends on kbs_pkg for field widths.
`default_nettype none
interface kbs_cmd_if import kbs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VEL_W-1:0] velocity;
	logic signed [SR_W-1:0]  steer_rate;
	modport source(output valid, velocity, steer_rate, input ready);
	modport sink(input valid, velocity, steer_rate, output ready);
endinterface

interface kbs_res_if import kbs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POS_W-1:0]   pos_x;
	logic signed [POS_W-1:0]   pos_y;
	logic signed [YAW_W-1:0]   heading;
	logic signed [STEER_W-1:0] steer_angle;
	modport source(output valid, pos_x, pos_y, heading, steer_angle, input ready);
	modport sink(input valid, pos_x, pos_y, heading, steer_angle, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/kbs_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, then rounding.
// Depends on kbs_pkg (atan table, widths, constants).
`default_nettype none
module kbs_cordic import kbs_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [YAW_W-1:0]  angle,
	output logic                          busy,
	output logic signed [TRIG_W-1:0]      cos_o,
	output logic signed [TRIG_W-1:0]      sin_o
);
	logic                    busy_q, flip_q;
	logic [CNT_W-1:0]        it_q;
	logic signed [CX_W-1:0]  x_q, y_q;
	logic signed [CZ_W-1:0]  z_q;
	logic signed [TRIG_W-1:0] cos_q, sin_q;

	logic signed [CZ_W-1:0]  z0, z_in, at;
	logic signed [CX_W-1:0]  xs, ys, xf, yf, xr, yr;

	always_comb begin
		z0 = CZ_W'(angle) <<< (CF - FRAC_BITS);
		// fold into [-pi/2, pi/2]; result sign is flipped back at the end
		if (z0 > HALF_Z)
			z_in = z0 - PI_Z;
		else if (z0 < -HALF_Z)
			z_in = z0 + PI_Z;
		else
			z_in = z0;
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		at = atan_lut(5'(it_q));
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		xr = (xf + CX_W'(RND)) >>> (CF - FRAC_BITS);
		yr = (yf + CX_W'(RND)) >>> (CF - FRAC_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q   <= '0;
			flip_q <= 1'b0;
			cos_q  <= '0;
			sin_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			it_q   <= '0;
			flip_q <= (z0 > HALF_Z) || (z0 < -HALF_Z);
			x_q    <= K_X;
			y_q    <= '0;
			z_q    <= z_in;
		end else if (busy_q) begin
			if (it_q == CNT_W'(CORDIC_ITERS)) begin
				cos_q  <= TRIG_W'(xr);
				sin_q  <= TRIG_W'(yr);
				busy_q <= 1'b0;
			end else begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				it_q <= it_q + 1'b1;
			end
		end
	end

	assign busy  = busy_q;
	assign cos_o = cos_q;
	assign sin_o = sin_q;
endmodule
`default_nettype wire

// ----- hw/rtl/kbs_div.sv -----
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on kbs_pkg for operand widths.
`default_nettype none
module kbs_div import kbs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DN_W-1:0]  num,
	input  wire logic [DD_W-1:0]  den,
	output logic                  busy,
	output logic [DN_W-1:0]       quot
);
	localparam int DC_W = $clog2(DN_W + 1);

	logic            busy_q;
	logic [DC_W-1:0] cnt_q;
	logic [DN_W-1:0] quo_q;
	logic [DD_W-1:0] rem_q, den_q;
	logic [DD_W:0]   sh, diff;

	always_comb begin
		sh   = {rem_q, quo_q[DN_W-1]};
		diff = sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DC_W'(DN_W);
			quo_q  <= num;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			// remainder stays below den, so a clear top bit of diff means it fit
			if (!diff[DD_W]) begin
				rem_q <= diff[DD_W-1:0];
				quo_q <= {quo_q[DN_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DD_W-1:0];
				quo_q <= {quo_q[DN_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DC_W'(1))
				busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule
`default_nettype wire

// ----- hw/rtl/kinematic_bicycle_step_top.sv -----
// Kinematic bicycle step: one request in, one pose result out.
// One request at a time, taken while the sequencer is idle: no new request is taken
// before the previous one is through, and a result not yet taken stalls the next request.
// Steps: a CORDIC pass (steering angle), a divider pass (yaw increment), then
// multiply-folds of the yaw wrap, on a shared 25x25 multiplier.
// arst_n clears pose, held input and control; config resets to 2.0 m and 0.1 s.
`default_nettype none
`include "assert_macros.svh"
module kinematic_bicycle_step_top import kbs_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [0:0]        cfg_idx,
	input  wire logic [LW_W-1:0]   cfg_data,
	kbs_cmd_if.sink                cmd,
	kbs_res_if.source              res
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_M_SR, ST_M_V, ST_VDT, ST_WC1, ST_M_DEN, ST_DEN, ST_NUM,
		ST_WD1, ST_T, ST_FM, ST_FA, ST_WC2, ST_M_X, ST_M_Y, ST_FIN
	} state_t;

	state_t state_q;

	logic [LW_W-1:0]             lw_q;
	logic [DT_W-1:0]             dt_q;
	logic signed [POS_W-1:0]     x_q, y_q;
	logic signed [YAW_W-1:0]     yaw_q, heading_q;
	logic signed [STEER_W-1:0]   steer_q, ns_q;
	logic signed [VEL_W-1:0]     hv_q, nv_q, vdt_q;
	logic signed [SR_W-1:0]      hsr_q, nsr_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [DD_W-1:0]      den_q;
	logic signed [T_W-1:0]       ypi_q, t_q;
	logic [DN_W-1:0]             md_q;
	logic                        neg_q, tneg_q, out_valid_q;

	logic signed [MOP_W-1:0]     mul_a, mul_b;
	logic signed [MOP_W-1:0]     dt_op, lw_op;
	logic                        cdc_start, cdc_busy, div_start, div_busy, accept;
	logic signed [YAW_W-1:0]     cdc_angle;
	logic signed [TRIG_W-1:0]    cdc_cos, cdc_sin;
	logic [DN_W-1:0]             div_num, div_quot;
	logic [DD_W-1:0]             div_den;
	logic signed [T_W-1:0]       ns_sum, prod_sh, quo_s, t_next, hd;
	logic signed [DD_W-1:0]      den_next;
	logic signed [PROD_W-1:0]    num_abs;
	logic signed [T_W-1:0]       t_abs;
	logic signed [DD_W:0]        den_abs;
	logic signed [POS_W+1:0]     pos_sum_x, pos_sum_y;
	logic [DN_W-1:0]             md_sum;
	logic [FOLD_K-1:0]           md_lo, md_rem;
	logic                        md_big;

	kbs_cordic u_cordic (
		.clk, .arst_n, .start(cdc_start), .angle(cdc_angle),
		.busy(cdc_busy), .cos_o(cdc_cos), .sin_o(cdc_sin)
	);

	kbs_div u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quot(div_quot)
	);

	assign accept = cmd.valid && cmd.ready;

	always_comb begin
		dt_op = MOP_W'({1'b0, dt_q});
		lw_op = MOP_W'({1'b0, lw_q});
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_M_SR:  begin mul_a = MOP_W'(hsr_q);   mul_b = dt_op; end
			ST_M_V:   begin mul_a = MOP_W'(hv_q);    mul_b = dt_op; end
			ST_M_DEN: begin mul_a = MOP_W'(cdc_cos); mul_b = lw_op; end
			ST_DEN:   begin mul_a = MOP_W'(vdt_q);   mul_b = MOP_W'(cdc_sin); end
			// |t| stays below 2^40, so the high part fits the positive operand range
			ST_FM:    begin mul_a = MOP_W'(md_q[DN_W-1:FOLD_K]); mul_b = FOLD_C; end
			ST_M_X:   begin mul_a = MOP_W'(vdt_q);   mul_b = MOP_W'(cdc_cos); end
			ST_M_Y:   begin mul_a = MOP_W'(vdt_q);   mul_b = MOP_W'(cdc_sin); end
			default:  begin mul_a = '0;              mul_b = '0; end
		endcase

		prod_sh   = T_W'(prod_q >>> FRAC_BITS);
		ns_sum    = T_W'(steer_q) + prod_sh;
		den_next  = DD_W'(prod_sh);
		if (den_next == '0)
			den_next = DD_W'(1);
		num_abs   = prod_q[PROD_W-1] ? -prod_q : prod_q;
		den_abs   = den_q[DD_W-1] ? -(DD_W+1)'(den_q) : (DD_W+1)'(den_q);
		quo_s     = neg_q ? -T_W'({2'b00, div_quot}) : T_W'({2'b00, div_quot});
		t_next    = ypi_q + quo_s;
		t_abs     = t_q[T_W-1] ? -t_q : t_q;
		// yaw wrap: hi*2^K + lo is congruent to hi*FOLD_C + lo modulo 2*pi
		md_lo     = md_q[FOLD_K-1:0];
		md_big    = (md_q[DN_W-1:FOLD_K] != '0);
		md_sum    = DN_W'(prod_q) + DN_W'(md_lo);
		md_rem    = (md_lo >= TWO_PI_R) ? md_lo - TWO_PI_R : md_lo;
		// floor modulo: a negative dividend with a nonzero remainder wraps up
		if (tneg_q && (md_rem != '0))
			hd = PI_T - T_W'({1'b0, md_rem});
		else
			hd = T_W'({1'b0, md_rem}) - PI_T;
		pos_sum_x = (POS_W+2)'(x_q) + (POS_W+2)'(prod_q >>> FRAC_BITS);
		pos_sum_y = (POS_W+2)'(y_q) + (POS_W+2)'(prod_q >>> FRAC_BITS);

		cdc_start = (state_q == ST_IDLE && accept) || (state_q == ST_WC1 && !cdc_busy);
		cdc_angle = (state_q == ST_IDLE) ? YAW_W'(steer_q) : yaw_q;
		div_start = (state_q == ST_NUM);
		div_num   = DN_W'(num_abs);
		div_den   = DD_W'(den_abs);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lw_q        <= LW_W'(131072);
			dt_q        <= DT_W'(6554);
			x_q         <= '0;
			y_q         <= '0;
			yaw_q       <= '0;
			steer_q     <= '0;
			hv_q        <= '0;
			hsr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			prod_q <= mul_a * mul_b;
			if (cfg_we) begin
				case (cfg_idx)
					REG_WHEELBASE: lw_q <= cfg_data;
					REG_TIME_STEP: dt_q <= cfg_data[DT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && res.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						nv_q    <= cmd.velocity;
						nsr_q   <= cmd.steer_rate;
						state_q <= ST_M_SR;
					end
				end
				ST_M_SR: state_q <= ST_M_V;
				ST_M_V: begin
					if (ns_sum > PI4_T)
						ns_q <= STEER_W'(PI4_T);
					else if (ns_sum < -PI4_T)
						ns_q <= STEER_W'(-PI4_T);
					else
						ns_q <= STEER_W'(ns_sum);
					state_q <= ST_VDT;
				end
				ST_VDT: begin
					vdt_q   <= VEL_W'(prod_sh);
					ypi_q   <= T_W'(yaw_q) + PI_T;
					state_q <= ST_WC1;
				end
				ST_WC1: begin
					if (!cdc_busy)
						state_q <= ST_M_DEN;
				end
				ST_M_DEN: state_q <= ST_DEN;
				ST_DEN: begin
					den_q   <= den_next;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					neg_q   <= prod_q[PROD_W-1] ^ den_q[DD_W-1];
					state_q <= ST_WD1;
				end
				ST_WD1: begin
					if (!div_busy) begin
						t_q     <= t_next;
						state_q <= ST_T;
					end
				end
				ST_T: begin
					tneg_q  <= t_q[T_W-1];
					md_q    <= DN_W'(t_abs);
					state_q <= ST_FM;
				end
				ST_FM: begin
					if (md_big)
						state_q <= ST_FA;
					else begin
						heading_q <= YAW_W'(hd);
						state_q   <= ST_WC2;
					end
				end
				ST_FA: begin
					md_q    <= md_sum;
					state_q <= ST_FM;
				end
				ST_WC2: begin
					// pose registers are the result payload: wait until it is taken
					if (!cdc_busy && (!out_valid_q || res.ready))
						state_q <= ST_M_X;
				end
				ST_M_X: state_q <= ST_M_Y;
				ST_M_Y: begin
					x_q     <= sat_pos(pos_sum_x);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					y_q         <= sat_pos(pos_sum_y);
					yaw_q       <= heading_q;
					steer_q     <= ns_q;
					hv_q        <= nv_q;
					hsr_q       <= nsr_q;
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.ready       = (state_q == ST_IDLE);
	assign res.valid       = out_valid_q;
	assign res.pos_x       = x_q;
	assign res.pos_y       = y_q;
	assign res.heading     = yaw_q;
	assign res.steer_angle = steer_q;

	`KBS_ASSERT_IMP(a_idle_units, cmd.ready, !cdc_busy && !div_busy)
	`KBS_ASSERT_NXT(a_busy_after_req, accept, !cmd.ready)
	`KBS_ASSERT(a_steer_range, T_W'(steer_q) <= PI4_T && T_W'(steer_q) >= -PI4_T)
	`KBS_ASSERT(a_yaw_range, T_W'(yaw_q) < PI_T && T_W'(yaw_q) >= -PI_T)
endmodule
`default_nettype wire

// ----- tb/tb_kinematic_bicycle_step_top.sv -----
// Self-checking testbench for kinematic_bicycle_step_top: directed and random requests, pose prediction.
// Depends on kbs_pkg and the kbs_cmd_if / kbs_res_if interfaces of the RTL.
`default_nettype none
module tb_kinematic_bicycle_step_top;
	import kbs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [YAW_W-1:0]   heading;
		logic signed [STEER_W-1:0] steer_angle;
	} pose_t;

	class pose_tracker;
		longint lw, dt;
		longint x, y, yaw, steer, hold_vel, hold_sr;
		pose_t  poses[$];
		int     errors;
		longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
			131072, 65536, 32768};

		function new();
			lw = 131072;
			dt = 6554;
			x = 0; y = 0; yaw = 0; steer = 0; hold_vel = 0; hold_sr = 0;
			errors = 0;
		endfunction

		function void configure(logic [0:0] idx, logic [LW_W-1:0] data);
			if (idx == REG_WHEELBASE)
				lw = longint'({1'b0, data});
			else
				dt = longint'({1'b0, data[DT_W-1:0]});
		endfunction

		// rotation-mode CORDIC, angle in Q16, results rounded back to Q16
		function void rotate(longint ang, output longint c, output longint s);
			longint z, cx, cy, t;
			bit flip;
			z = ang <<< (CF - FRAC_BITS);
			cx = CORDIC_K;
			cy = 0;
			flip = 0;
			if (z > HALF_PI_Q30) begin
				z -= PI_Q30;
				flip = 1;
			end else if (z < -HALF_PI_Q30) begin
				z += PI_Q30;
				flip = 1;
			end
			for (int i = 0; i < CORDIC_ITERS; i++) begin
				if (z >= 0) begin
					t = cx - (cy >>> i);
					cy = cy + (cx >>> i);
					z -= atan_tab[i];
				end else begin
					t = cx + (cy >>> i);
					cy = cy - (cx >>> i);
					z += atan_tab[i];
				end
				cx = t;
			end
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end
			c = (cx + RND) >>> (CF - FRAC_BITS);
			s = (cy + RND) >>> (CF - FRAC_BITS);
		endfunction

		function longint clip32(longint v);
			if (v > 64'sh7FFF_FFFF)
				return 64'sh7FFF_FFFF;
			if (v < -64'sh8000_0000)
				return -64'sh8000_0000;
			return v;
		endfunction

		function void note(logic signed [VEL_W-1:0] vel, logic signed [SR_W-1:0] sr);
			longint ns, ny, vdt, sc, ss, yc, ys, den, r;
			logic signed [YAW_W-1:0]   yaw_w;
			logic signed [STEER_W-1:0] steer_w;
			pose_t p;
			ns = steer + ((hold_sr * dt) >>> FRAC_BITS);
			if (ns > PI4_FRAC)
				ns = PI4_FRAC;
			else if (ns < -PI4_FRAC)
				ns = -PI4_FRAC;
			vdt = (hold_vel * dt) >>> FRAC_BITS;
			rotate(steer, sc, ss);
			den = (sc * lw) >>> FRAC_BITS;
			if (den == 0)
				den = 1;
			ny = yaw + (vdt * ss) / den;
			r = (ny + PI_FRAC) % (2 * PI_FRAC);
			if (r < 0)
				r += 2 * PI_FRAC;
			ny = r - PI_FRAC;
			rotate(yaw, yc, ys);
			x = clip32(x + ((vdt * yc) >>> FRAC_BITS));
			y = clip32(y + ((vdt * ys) >>> FRAC_BITS));
			yaw_w = ny[YAW_W-1:0];
			steer_w = ns[STEER_W-1:0];
			yaw = yaw_w;
			steer = steer_w;
			hold_vel = vel;
			hold_sr = sr;
			p.pos_x = x[POS_W-1:0];
			p.pos_y = y[POS_W-1:0];
			p.heading = yaw_w;
			p.steer_angle = steer_w;
			poses.push_back(p);
		endfunction

		function void report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endfunction

		function void check(pose_t got);
			pose_t want;
			if (poses.size() == 0) begin
				report("unexpected result, pos_x", got.pos_x, 0);
				return;
			end
			want = poses.pop_front();
			if (got.pos_x !== want.pos_x)
				report("pos_x", got.pos_x, want.pos_x);
			if (got.pos_y !== want.pos_y)
				report("pos_y", got.pos_y, want.pos_y);
			if (got.heading !== want.heading)
				report("heading", got.heading, want.heading);
			if (got.steer_angle !== want.steer_angle)
				report("steer_angle", got.steer_angle, want.steer_angle);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [0:0]        cfg_idx;
	logic [LW_W-1:0]   cfg_data;

	kbs_cmd_if cmd ();
	kbs_res_if res ();

	kinematic_bicycle_step_top uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .cmd(cmd.sink), .res(res.source)
	);

	pose_tracker poses_sb = new();
	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	bit  hold_req = 0;
	int  quiet_cycles = 0;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_idx = REG_WHEELBASE;
		cfg_data = '0;
		cmd.valid = 0;
		cmd.velocity = '0;
		cmd.steer_rate = '0;
		res.ready = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
	end

	// result side; a hold-off request parks ready low for a long stretch
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req && hold_cnt == 0) begin
				hold_cnt = 600;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res.ready <= 1'b0;
			end else
				res.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pose_t got;
		if (arst_n) begin
			if (cmd.valid && cmd.ready)
				poses_sb.note(cmd.velocity, cmd.steer_rate);
			if (res.valid && res.ready) begin
				got.pos_x = res.pos_x;
				got.pos_y = res.pos_y;
				got.heading = res.heading;
				got.steer_angle = res.steer_angle;
				poses_sb.check(got);
			end
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 20000) begin
				$display("[kinematic_bicycle_step_top] ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [0:0] idx, logic [LW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		poses_sb.configure(idx, data);
		@(posedge clk);
	endtask

	task automatic send(logic signed [VEL_W-1:0] vel, logic signed [SR_W-1:0] sr);
		cmd.valid <= 1'b1;
		cmd.velocity <= vel;
		cmd.steer_rate <= sr;
		do @(posedge clk); while (!cmd.ready);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		cmd.valid <= 1'b0;
		@(posedge clk);
		while (poses_sb.poses.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// cruise biases toward long straight runs so position saturates
	task automatic send_random(int n, bit cruise);
		logic signed [VEL_W-1:0] vel;
		logic signed [SR_W-1:0]  sr;
		repeat (n) begin
			vel = VEL_W'($urandom);
			sr = SR_W'($urandom);
			if (cruise && $urandom_range(9) < 8) begin
				vel = VEL_W'($urandom_range(24'h7FFFFF, 24'h600000));
				sr = SR_W'(int'($urandom_range(255)) - 128);
			end
			send(vel, sr);
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// directed: field extremes at reset settings
		send(24'sh7FFFFF, 21'sh0FFFFF);
		send(24'sh7FFFFF, 21'sh0FFFFF);
		send(-24'sh800000, -21'sh100000);
		send(-24'sh800000, -21'sh100000);
		send(24'sh000000, 21'sh000000);
		send(24'sh000001, 21'sh000001);
		send(-24'sh000001, -21'sh000001);
		send(24'sh7FFFFF, 21'sh000000);
		drain();

		// zero wheelbase forces the one-LSB divisor and big yaw wraps;
		// junk in the high data bits must be masked off
		write_reg(REG_WHEELBASE, 24'h000000);
		write_reg(REG_TIME_STEP, 24'hA5FFFF);
		send(24'sh7FFFFF, 21'sh0FFFFF);
		send(24'sh7FFFFF, 21'sh000000);
		send(-24'sh800000, -21'sh100000);
		send(-24'sh800000, 21'sh000000);
		send(24'sh400000, 21'sh080000);
		send(24'sh000000, 21'sh000000);
		drain();

		write_reg(REG_WHEELBASE, 24'd6554);
		write_reg(REG_TIME_STEP, 24'd1);
		send_random(150, 0);
		drain();

		send_idle_pct = 48;
		write_reg(REG_WHEELBASE, 24'hFFFFFF);
		write_reg(REG_TIME_STEP, 24'd65535);
		send_random(300, 1);
		drain();

		send_idle_pct = 0;
		recv_stall_pct = 48;
		hold_req = 1;
		write_reg(REG_WHEELBASE, 24'($urandom_range(16777215, 6554)));
		write_reg(REG_TIME_STEP, 24'($urandom_range(65535, 1)));
		send_random(150, 0);
		drain();

		send_idle_pct = 21;
		recv_stall_pct = 21;
		write_reg(REG_WHEELBASE, 24'd131072);
		write_reg(REG_TIME_STEP, 24'd6554);
		send_random(180, 0);
		drain();

		if (poses_sb.errors == 0)
			$display("[kinematic_bicycle_step_top] OK");
		else
			$display("[kinematic_bicycle_step_top] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
